/* sv/rfdc_pkg.sv */
// ----------------------------------------------------------------------------
// rfdc_pkg: shared types and constants
// Field widths, register indexes, reset values and inter-module status
// structs for the reciprocal frequency and duty counter.
// ----------------------------------------------------------------------------
package rfdc_pkg;

  localparam int CLK_HZ_W   = 27;
  localparam int MIN_GATE_W = 32;
  localparam int EDGE_W     = 32;
  localparam int OUT_TICK_W = 48;
  localparam int FREQ_W     = 48;
  localparam int DUTY_W     = 17;
  localparam int Q16_SHIFT  = 16;
  localparam int PROD_W     = EDGE_W + CLK_HZ_W;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GATE = 1'b1;

  localparam logic [CLK_HZ_W-1:0]   RESET_CLOCK_HZ = 27'd20000000;
  localparam logic [MIN_GATE_W-1:0] RESET_MIN_GATE = 32'd500000;
  localparam logic [DUTY_W-1:0]     Q16_ONE        = 17'h10000;

  typedef struct packed {
    logic full;
    logic empty;
  } rfdc_q_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rfdc_div_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DUTY = 5'b00100,
    ST_FREQ = 5'b01000,
    ST_OUT  = 5'b10000
  } rfdc_back_state_t;

endpackage

/* sv/rfdc_if.sv */
// ----------------------------------------------------------------------------
// rfdc_if: stream interfaces
// Valid/ready channels for the sampled level and for measurement results.
// ----------------------------------------------------------------------------
interface rfdc_in_if;
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface rfdc_out_if;
  logic                            valid;
  logic                            ready;
  logic [rfdc_pkg::OUT_TICK_W-1:0] period_ticks;
  logic [rfdc_pkg::EDGE_W-1:0]     edge_count;
  logic [rfdc_pkg::OUT_TICK_W-1:0] high_ticks;
  logic [rfdc_pkg::FREQ_W-1:0]     freq_q16;
  logic [rfdc_pkg::DUTY_W-1:0]     duty_q16;

  modport source (output valid, output period_ticks, output edge_count,
                  output high_ticks, output freq_q16, output duty_q16,
                  input ready);
  modport sink   (input valid, input period_ticks, input edge_count,
                  input high_ticks, input freq_q16, input duty_q16,
                  output ready);
  modport monitor (input valid, input ready, input period_ticks, input edge_count,
                   input high_ticks, input freq_q16, input duty_q16);
endinterface

/* sv/rfdc_front.sv */
// ----------------------------------------------------------------------------
// rfdc_front: edge detector and gate counters
// Takes one level sample per transfer, tracks the gate and pushes a job
// (elapsed, edges, high time) when a closing edge ends the gate.
// ----------------------------------------------------------------------------
module rfdc_front #(
  parameter int TICK_BITS = 48
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  rfdc_in_if.sink                                    in_ch,
  input  logic [rfdc_pkg::MIN_GATE_W-1:0]            min_gate,
  input  rfdc_pkg::rfdc_q_stat_t                     q_stat,
  output logic                                       push,
  output logic [2*TICK_BITS+rfdc_pkg::EDGE_W-1:0]    job
);

  localparam logic [TICK_BITS-1:0]        TICK_MAX = '1;
  localparam logic [rfdc_pkg::EDGE_W-1:0] EDGE_MAX = '1;

  logic                        prev_r, prev_nxt;
  logic                        armed_r, armed_nxt;
  logic [TICK_BITS-1:0]        el_r, el_nxt, el_inc;
  logic [TICK_BITS-1:0]        ht_r, ht_nxt, ht_inc;
  logic [rfdc_pkg::EDGE_W-1:0] ed_r, ed_nxt, ed_inc;
  logic                        accept, rising, gate_done;

  assign in_ch.ready = ~q_stat.full;

  always_comb begin
    accept    = in_ch.valid & in_ch.ready;
    rising    = in_ch.level & ~prev_r;
    el_inc    = (el_r != TICK_MAX) ? el_r + 1'b1 : el_r;
    ht_inc    = (in_ch.level && (ht_r != TICK_MAX)) ? ht_r + 1'b1 : ht_r;
    ed_inc    = (ed_r != EDGE_MAX) ? ed_r + 1'b1 : ed_r;
    gate_done = 64'(el_inc) >= 64'(min_gate);
    job       = {el_inc, ed_inc, ht_inc};

    prev_nxt  = prev_r;
    armed_nxt = armed_r;
    el_nxt    = el_r;
    ht_nxt    = ht_r;
    ed_nxt    = ed_r;
    push      = 1'b0;

    if (accept) begin
      prev_nxt = in_ch.level;
      if (!armed_r) begin
        if (rising) begin
          armed_nxt = 1'b1;
          el_nxt    = '0;
          ht_nxt    = '0;
          ed_nxt    = '0;
        end
      end else begin
        el_nxt = el_inc;
        ht_nxt = ht_inc;
        if (rising) begin
          ed_nxt = ed_inc;
          if (gate_done) begin
            // closing edge also opens the next gate
            push   = 1'b1;
            el_nxt = '0;
            ht_nxt = '0;
            ed_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      armed_r <= 1'b0;
      el_r    <= '0;
      ht_r    <= '0;
      ed_r    <= '0;
    end else begin
      prev_r  <= prev_nxt;
      armed_r <= armed_nxt;
      el_r    <= el_nxt;
      ht_r    <= ht_nxt;
      ed_r    <= ed_nxt;
    end
  end

endmodule

/* sv/rfdc_queue.sv */
// ----------------------------------------------------------------------------
// rfdc_queue: short job queue
// Small register FIFO between the counter front and the divide back end.
// ----------------------------------------------------------------------------
module rfdc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [W-1:0]           din,
  input  logic                   pop,
  output logic [W-1:0]           dout,
  output rfdc_pkg::rfdc_q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  always_comb begin
    stat.full  = (cnt_r == CW'(DEPTH));
    stat.empty = (cnt_r == '0);
    do_push    = push & ~stat.full;
    do_pop     = pop & ~stat.empty;
    dout       = mem_r[rd_r];
    wr_nxt     = wr_r;
    rd_nxt     = rd_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= din;
  end

endmodule

/* sv/rfdc_div.sv */
// ----------------------------------------------------------------------------
// rfdc_div: radix-2 restoring divider
// One quotient bit per cycle; done pulses once the last quotient bit is shifted in.
// ----------------------------------------------------------------------------
module rfdc_div #(
  parameter int DW = 75,
  parameter int VW = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DW-1:0]            dividend,
  input  logic [VW-1:0]            divisor,
  output logic [DW-1:0]            quotient,
  output rfdc_pkg::rfdc_div_stat_t stat
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd_r, dvd_nxt;
  logic [VW-1:0]    rem_r, rem_nxt, d_r, d_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [VW:0]      trial, diff;
  logic             ge;

  assign quotient  = dvd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  always_comb begin
    trial    = {rem_r, dvd_r[DW-1]};
    ge       = trial >= {1'b0, d_r};
    diff     = trial - {1'b0, d_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = CNT_W'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
      dvd_nxt = {dvd_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

endmodule

/* sv/rfdc_back.sv */
// ----------------------------------------------------------------------------
// rfdc_back: measurement sequencer
// Pops a job, forms edges * clock_hz, runs the duty and frequency divides
// on the shared divider and holds the result until transferred.
// ----------------------------------------------------------------------------
module rfdc_back #(
  parameter int TICK_BITS = 48
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [2*TICK_BITS+rfdc_pkg::EDGE_W-1:0] job,
  input  rfdc_pkg::rfdc_q_stat_t                  q_stat,
  output logic                                    pop,
  input  logic [rfdc_pkg::CLK_HZ_W-1:0]           clock_hz,
  rfdc_out_if.source                              out_ch
);

  localparam int PROD_W = rfdc_pkg::PROD_W;
  localparam int DW     = ((TICK_BITS > PROD_W) ? TICK_BITS : PROD_W) + rfdc_pkg::Q16_SHIFT;
  localparam int EDGE_W = rfdc_pkg::EDGE_W;

  rfdc_pkg::rfdc_back_state_t state_r, state_nxt;
  rfdc_pkg::rfdc_div_stat_t   div_stat;

  logic [TICK_BITS-1:0]          el_r, el_nxt, ht_r, ht_nxt;
  logic [EDGE_W-1:0]             ed_r, ed_nxt;
  logic [PROD_W-1:0]             prod_r, prod_nxt;
  logic [rfdc_pkg::DUTY_W-1:0]   duty_r, duty_nxt;
  logic [rfdc_pkg::FREQ_W-1:0]   freq_r, freq_nxt;
  logic                          div_start;
  logic [DW-1:0]                 div_dividend, div_q;
  logic [63:0]                   el_ext, ht_ext;

  rfdc_div #(.DW(DW), .VW(TICK_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (el_r),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt    = state_r;
    el_nxt       = el_r;
    ht_nxt       = ht_r;
    ed_nxt       = ed_r;
    prod_nxt     = prod_r;
    duty_nxt     = duty_r;
    freq_nxt     = freq_r;
    pop          = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    case (state_r)
      rfdc_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          {el_nxt, ed_nxt, ht_nxt} = job;
          state_nxt = rfdc_pkg::ST_MUL;
        end
      end
      rfdc_pkg::ST_MUL: begin
        prod_nxt     = ed_r * clock_hz;
        div_start    = 1'b1;
        div_dividend = DW'(ht_r) << rfdc_pkg::Q16_SHIFT;
        state_nxt    = rfdc_pkg::ST_DUTY;
      end
      rfdc_pkg::ST_DUTY: begin
        if (div_stat.done) begin
          duty_nxt     = (div_q > DW'(rfdc_pkg::Q16_ONE)) ? rfdc_pkg::Q16_ONE
                                                         : div_q[rfdc_pkg::DUTY_W-1:0];
          div_start    = 1'b1;
          div_dividend = DW'(prod_r) << rfdc_pkg::Q16_SHIFT;
          state_nxt    = rfdc_pkg::ST_FREQ;
        end
      end
      rfdc_pkg::ST_FREQ: begin
        if (div_stat.done) begin
          freq_nxt  = div_q[rfdc_pkg::FREQ_W-1:0];
          state_nxt = rfdc_pkg::ST_OUT;
        end
      end
      rfdc_pkg::ST_OUT: begin
        if (out_ch.ready) state_nxt = rfdc_pkg::ST_IDLE;
      end
      default: state_nxt = rfdc_pkg::ST_IDLE;
    endcase
  end

  // saturate tick counts to the 48-bit result fields
  always_comb begin
    el_ext              = 64'(el_r);
    ht_ext              = 64'(ht_r);
    out_ch.valid        = (state_r == rfdc_pkg::ST_OUT);
    out_ch.period_ticks = (el_ext[63:48] != '0) ? '1 : el_ext[47:0];
    out_ch.high_ticks   = (ht_ext[63:48] != '0) ? '1 : ht_ext[47:0];
    out_ch.edge_count   = ed_r;
    out_ch.freq_q16     = freq_r;
    out_ch.duty_q16     = duty_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rfdc_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    el_r   <= el_nxt;
    ht_r   <= ht_nxt;
    ed_r   <= ed_nxt;
    prod_r <= prod_nxt;
    duty_r <= duty_nxt;
    freq_r <= freq_nxt;
  end

endmodule

/* sv/reciprocal_frequency_duty_counter.sv */
// ----------------------------------------------------------------------------
// reciprocal_frequency_duty_counter: gated period, frequency and duty meter
// Counts ticks, rising edges and high time of a sampled signal per gate and
// reports each gate as a measurement with Q16 frequency and duty quotients.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transfer per clock tick, payload = sampled level.
//   out_ch : one measurement per closed gate (period, edges, high time,
//            freq_q16, duty_q16).
//   cfg_*  : write clock_hz (index 0) and min_gate_ticks (index 1) while idle.
// Throughput: in_ch takes one tick per cycle while the job queue has room.
// Result path: a closing edge's job is multiplied, then runs the duty divide
//   and the frequency divide on the single shared bit-serial divider, whose
//   dividend width is DW = max(TICK_BITS, 59) + 16. Gates closing faster
//   than the back end finishes jobs fill the job queue (QUEUE_DEPTH entries);
//   in_ch.ready then drops until the back end frees a slot.
// Reset: gate disarmed, counters and queue empty, registers at 20 MHz and
//   500000 ticks. The first rising level after reset opens the first gate.
// Stall: a result waits in the output register while out_ch.ready is low;
//   the front keeps counting and queues further jobs while the queue has room.
// ----------------------------------------------------------------------------
module reciprocal_frequency_duty_counter #(
  parameter int TICK_BITS   = 48,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rfdc_in_if.sink                          in_ch,
  rfdc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [rfdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rfdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int JOB_W = 2*TICK_BITS + rfdc_pkg::EDGE_W;

  // configuration registers
  logic [rfdc_pkg::CLK_HZ_W-1:0]   clock_hz_r, clock_hz_nxt;
  logic [rfdc_pkg::MIN_GATE_W-1:0] min_gate_r, min_gate_nxt;

  // front -> queue -> back
  logic                   push, pop;
  logic [JOB_W-1:0]       job_in, job_out;
  rfdc_pkg::rfdc_q_stat_t q_stat;

  always_comb begin
    clock_hz_nxt = clock_hz_r;
    min_gate_nxt = min_gate_r;
    if (cfg_we) begin
      case (cfg_index)
        rfdc_pkg::CFG_CLOCK_HZ: clock_hz_nxt = cfg_data[rfdc_pkg::CLK_HZ_W-1:0];
        rfdc_pkg::CFG_MIN_GATE: min_gate_nxt = cfg_data[rfdc_pkg::MIN_GATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= rfdc_pkg::RESET_CLOCK_HZ;
      min_gate_r <= rfdc_pkg::RESET_MIN_GATE;
    end else begin
      clock_hz_r <= clock_hz_nxt;
      min_gate_r <= min_gate_nxt;
    end
  end

  rfdc_front #(.TICK_BITS(TICK_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .min_gate (min_gate_r),
    .q_stat   (q_stat),
    .push     (push),
    .job      (job_in)
  );

  rfdc_queue #(.W(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (job_in),
    .pop   (pop),
    .dout  (job_out),
    .stat  (q_stat)
  );

  rfdc_back #(.TICK_BITS(TICK_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job_out),
    .q_stat   (q_stat),
    .pop      (pop),
    .clock_hz (clock_hz_r),
    .out_ch   (out_ch)
  );

endmodule

/* sv/rfdc_checker.sv */
// ----------------------------------------------------------------------------
// rfdc_checker: port-level checks
// Result channel hold behavior and consistency between result fields.
// ----------------------------------------------------------------------------
module rfdc_checker (
  input logic        clk,
  input logic        rst_n,
  rfdc_out_if.source out_ch
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.period_ticks)
      && $stable(out_ch.freq_q16) && $stable(out_ch.duty_q16))
    else $error("result changed while stalled");

  a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.duty_q16 <= rfdc_pkg::Q16_ONE)
    else $error("duty above one");

  a_high_le_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.high_ticks <= out_ch.period_ticks)
    else $error("high time exceeds period");

  // closing edge is always counted and takes at least one tick
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.edge_count != '0) && (out_ch.period_ticks != '0))
    else $error("empty gate reported");

endmodule

bind reciprocal_frequency_duty_counter rfdc_checker u_rfdc_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_ch (out_ch)
);
